[hw/rtl/prefix_code_trie_decoder_core_defines.svh]
// Assertion helpers used by the checker file.
`ifndef PREFIX_CODE_TRIE_DECODER_CORE_DEFINES_SVH
`define PREFIX_CODE_TRIE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define PCTD_ASSERT_NOW(name, clk_s, rstn_s, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PCTD_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/pctd_pkg.sv]
`default_nettype none

package pctd_pkg;

	localparam int DEF_MAX_NODES    = 1024;
	localparam int DEF_MAX_CODE_LEN = 32;
	localparam int DEF_SYMBOL_BITS  = 9;

	localparam int OPCODE_W   = 2;
	localparam int SYM_PORT_W = 9;
	localparam int CODE_W     = 32;
	localparam int LEN_W      = 6;
	localparam int STATUS_W   = 2;

	localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_DECODE = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	// which result the datapath loads into the output register
	typedef enum logic [1:0] {
		RES_ZERO,
		RES_MISS,
		RES_FULL,
		RES_EVAL
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     clear;
		logic     ins_alloc;
		logic     ins_descend;
		logic     ins_fill;
		logic     ins_flush;
		logic     dec_next;
		logic     dec_miss;
		logic     dec_eval;
		logic     res_load;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic ins_done;
		logic ins_has;
		logic ins_full;
		logic dec_has;
	} sts_t;

endpackage

`default_nettype wire

[hw/rtl/pctd_ram.sv]
`default_nettype none

module pctd_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/pctd_ctrl.sv]
`default_nettype none

module pctd_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [pctd_pkg::OPCODE_W-1:0]  opcode,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output pctd_pkg::cmd_t                      cmd,
	input  wire pctd_pkg::sts_t                 sts
);

	import pctd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_NOP,
		S_INS,
		S_FILL,
		S_DEC_CHILD,
		S_DEC_EVAL
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	// a result may be loaded when the output register is empty or being drained
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					unique case (opcode)
						OP_CLEAR:  state_nxt = S_CLEAR;
						OP_INSERT: state_nxt = S_INS;
						OP_DECODE: state_nxt = S_DEC_CHILD;
						default:   state_nxt = S_NOP;
					endcase
				end
			end
			S_CLEAR: begin
				if (out_free) begin
					cmd.clear    = 1'b1;
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_ZERO;
					state_nxt    = S_IDLE;
				end
			end
			S_NOP: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_ZERO;
					state_nxt    = S_IDLE;
				end
			end
			S_INS: begin
				priority if (sts.ins_done) begin
					if (out_free) begin
						cmd.ins_flush = 1'b1;
						cmd.res_load  = 1'b1;
						cmd.res_sel   = RES_ZERO;
						state_nxt     = S_IDLE;
					end
				end else if (sts.ins_has) begin
					cmd.ins_descend = 1'b1;
					state_nxt       = S_FILL;
				end else if (sts.ins_full) begin
					if (out_free) begin
						cmd.ins_flush = 1'b1;
						cmd.res_load  = 1'b1;
						cmd.res_sel   = RES_FULL;
						state_nxt     = S_IDLE;
					end
				end else begin
					cmd.ins_alloc = 1'b1;
				end
			end
			S_FILL: begin
				cmd.ins_fill = 1'b1;
				state_nxt    = S_INS;
			end
			S_DEC_CHILD: begin
				if (!sts.dec_has) begin
					if (out_free) begin
						cmd.dec_miss = 1'b1;
						cmd.res_load = 1'b1;
						cmd.res_sel  = RES_MISS;
						state_nxt    = S_IDLE;
					end
				end else begin
					cmd.dec_next = 1'b1;
					state_nxt    = S_DEC_EVAL;
				end
			end
			S_DEC_EVAL: begin
				if (out_free) begin
					cmd.dec_eval = 1'b1;
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_EVAL;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/pctd_dp.sv]
`default_nettype none

module pctd_dp #(
	parameter int MAX_NODES    = pctd_pkg::DEF_MAX_NODES,
	parameter int MAX_CODE_LEN = pctd_pkg::DEF_MAX_CODE_LEN,
	parameter int SYMBOL_BITS  = pctd_pkg::DEF_SYMBOL_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire pctd_pkg::cmd_t                   cmd,
	output pctd_pkg::sts_t                        sts,
	input  wire logic [pctd_pkg::SYM_PORT_W-1:0]  symbol,
	input  wire logic [pctd_pkg::CODE_W-1:0]      code_bits,
	input  wire logic [pctd_pkg::LEN_W-1:0]       code_length,
	input  wire logic                             bit_req,
	output logic                                  symbol_found,
	output logic      [pctd_pkg::SYM_PORT_W-1:0]  decoded_symbol,
	output logic      [pctd_pkg::STATUS_W-1:0]    status
);

	import pctd_pkg::*;

	localparam int NODE_W  = $clog2(MAX_NODES);
	localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam logic [NODE_W:0]    NODE_LIMIT = (NODE_W + 1)'(MAX_NODES);
	localparam logic [LEN_W-1:0]   LEN_LIMIT  = LEN_W'(LEN_CAP);
	localparam int BIT_SEL_W = $clog2(CODE_W);

	typedef struct packed {
		logic                   has_l;
		logic                   has_r;
		logic [NODE_W-1:0]      l;
		logic [NODE_W-1:0]      r;
		logic [SYMBOL_BITS-1:0] sym;
	} node_t;

	localparam int NODE_BITS = $bits(node_t);

	// latched item
	logic [SYMBOL_BITS-1:0] sym_q;
	logic [CODE_W-1:0]      bits_q;
	logic [LEN_W-1:0]       len_q;
	logic                   bit_q;

	// tree state; the root lives in flops, every other node in the RAM
	node_t             root_q;
	logic [NODE_W:0]   free_q;
	logic [NODE_W-1:0] cur_q;

	// insert walk: cached copy of the node at at_q, written back when dirty or on a child allocation
	node_t             cache_q;
	logic              dirty_q;
	logic [NODE_W-1:0] at_q;
	logic [LEN_W-1:0]  idx_q;
	logic [NODE_W-1:0] child_q;

	logic                  found_q;
	logic [SYM_PORT_W-1:0] dsym_q;
	logic [STATUS_W-1:0]   status_q;

	logic [NODE_BITS-1:0] rd_data;
	logic                 ram_we;
	logic                 ram_re;
	logic [NODE_W-1:0]    ram_raddr;

	node_t                          rd_node;
	node_t                          cur_node;
	node_t                          cache_upd;
	node_t                          fresh;
	node_t                          wr_node;
	logic                           ins_right;
	logic [NODE_W-1:0]              ins_child;
	logic [NODE_W-1:0]              dec_child;
	logic                           wr_go;
	logic                           leafish;
	logic [LEN_W-1:0]               len_eff;
	logic [SYMBOL_BITS+SYM_PORT_W-1:0] sym_in_ext;
	logic [SYMBOL_BITS+SYM_PORT_W-1:0] sym_out_ext;

	assign rd_node  = node_t'(rd_data);
	assign cur_node = (cur_q == '0) ? root_q : rd_node;

	assign len_eff    = (code_length > LEN_LIMIT) ? LEN_LIMIT : code_length;
	assign sym_in_ext = {{SYMBOL_BITS{1'b0}}, symbol};
	assign sym_out_ext = {{SYM_PORT_W{1'b0}}, rd_node.sym};

	assign ins_right = bits_q[idx_q[BIT_SEL_W-1:0]];
	assign ins_child = ins_right ? cache_q.r : cache_q.l;
	assign dec_child = bit_q ? cur_node.r : cur_node.l;
	assign leafish   = !rd_node.has_l || !rd_node.has_r;

	assign sts.ins_done = (idx_q == len_q);
	assign sts.ins_has  = ins_right ? cache_q.has_r : cache_q.has_l;
	assign sts.ins_full = (free_q >= NODE_LIMIT);
	assign sts.dec_has  = bit_q ? cur_node.has_r : cur_node.has_l;

	always_comb begin
		cache_upd = cache_q;
		if (ins_right) begin
			cache_upd.has_r = 1'b1;
			cache_upd.r     = free_q[NODE_W-1:0];
		end else begin
			cache_upd.has_l = 1'b1;
			cache_upd.l     = free_q[NODE_W-1:0];
		end
	end

	always_comb begin
		fresh       = '0;
		fresh.sym   = sym_q;
	end

	assign wr_node = cmd.ins_alloc ? cache_upd : cache_q;
	assign wr_go   = cmd.ins_alloc || ((cmd.ins_descend || cmd.ins_flush) && dirty_q);
	assign ram_we  = wr_go && (at_q != '0);

	assign ram_re = cmd.capture || cmd.ins_descend || cmd.dec_next;

	always_comb begin
		priority if (cmd.ins_descend) begin
			ram_raddr = ins_child;
		end else if (cmd.dec_next) begin
			ram_raddr = dec_child;
		end else begin
			ram_raddr = cur_q;
		end
	end

	pctd_ram #(
		.WIDTH (NODE_BITS),
		.DEPTH (MAX_NODES)
	) u_nodes (
		.clk   (clk),
		.we    (ram_we),
		.waddr (at_q),
		.wdata (wr_node),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_data)
	);

	// tree state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
			free_q <= (NODE_W + 1)'(1);
			cur_q  <= '0;
		end else begin
			if (cmd.clear) begin
				root_q <= '0;
				free_q <= (NODE_W + 1)'(1);
				cur_q  <= '0;
			end else begin
				if (wr_go && (at_q == '0)) begin
					root_q <= wr_node;
				end
				if (cmd.ins_alloc) begin
					free_q <= free_q + (NODE_W + 1)'(1);
				end
				if (cmd.dec_miss) begin
					cur_q <= '0;
				end else if (cmd.dec_eval) begin
					cur_q <= leafish ? '0 : child_q;
				end
			end
		end
	end

	// item and walk registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sym_q   <= sym_in_ext[SYMBOL_BITS-1:0];
			bits_q  <= code_bits;
			len_q   <= len_eff;
			bit_q   <= bit_req;
			cache_q <= root_q;
			dirty_q <= 1'b0;
			at_q    <= '0;
			idx_q   <= '0;
		end else if (cmd.ins_alloc) begin
			cache_q <= fresh;
			dirty_q <= 1'b1;
			at_q    <= free_q[NODE_W-1:0];
			idx_q   <= idx_q + LEN_W'(1);
		end else if (cmd.ins_descend) begin
			at_q  <= ins_child;
			idx_q <= idx_q + LEN_W'(1);
		end else if (cmd.ins_fill) begin
			cache_q <= rd_node;
			dirty_q <= 1'b0;
		end
		if (cmd.dec_next) begin
			child_q <= dec_child;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			unique case (cmd.res_sel)
				RES_ZERO: begin
					found_q  <= 1'b0;
					dsym_q   <= '0;
					status_q <= STATUS_OK;
				end
				RES_MISS: begin
					found_q  <= 1'b0;
					dsym_q   <= '0;
					status_q <= STATUS_MISS;
				end
				RES_FULL: begin
					found_q  <= 1'b0;
					dsym_q   <= '0;
					status_q <= STATUS_FULL;
				end
				RES_EVAL: begin
					found_q  <= leafish;
					dsym_q   <= leafish ? sym_out_ext[SYM_PORT_W-1:0] : '0;
					status_q <= STATUS_OK;
				end
			endcase
		end
	end

	assign symbol_found   = found_q;
	assign decoded_symbol = dsym_q;
	assign status         = status_q;

endmodule

`default_nettype wire

[hw/rtl/prefix_code_trie_decoder_core.sv]
// Per item: clear and an unknown opcode go straight to loading the result; decode reads the
// child, then evaluates it (a missing child ends it at once with a miss); insert allocates
// each new node and walks each existing node (one node-table RAM read per existing node).
// Result register is loaded on the return to idle; a waiting result stalls the last step.
// Asynchronous reset empties the root, sets the free pointer to 1 and the decode position
// to the root; the node RAM is not swept.
`default_nettype none

module prefix_code_trie_decoder_core #(
	parameter int MAX_NODES    = pctd_pkg::DEF_MAX_NODES,
	parameter int MAX_CODE_LEN = pctd_pkg::DEF_MAX_CODE_LEN,
	parameter int SYMBOL_BITS  = pctd_pkg::DEF_SYMBOL_BITS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [pctd_pkg::OPCODE_W-1:0]    opcode,
	input  wire logic [pctd_pkg::SYM_PORT_W-1:0]  symbol,
	input  wire logic [pctd_pkg::CODE_W-1:0]      code_bits,
	input  wire logic [pctd_pkg::LEN_W-1:0]       code_length,
	input  wire logic                             bit_req,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  symbol_found,
	output logic      [pctd_pkg::SYM_PORT_W-1:0]  decoded_symbol,
	output logic      [pctd_pkg::STATUS_W-1:0]    status
);

	import pctd_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pctd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pctd_dp #(
		.MAX_NODES    (MAX_NODES),
		.MAX_CODE_LEN (MAX_CODE_LEN),
		.SYMBOL_BITS  (SYMBOL_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.symbol         (symbol),
		.code_bits      (code_bits),
		.code_length    (code_length),
		.bit_req        (bit_req),
		.symbol_found   (symbol_found),
		.decoded_symbol (decoded_symbol),
		.status         (status)
	);

endmodule

`default_nettype wire

[hw/rtl/pctd_checker.sv]
`default_nettype none

`include "prefix_code_trie_decoder_core_defines.svh"

module pctd_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             in_valid,
	input wire logic                             in_ready,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic                             symbol_found,
	input wire logic [pctd_pkg::SYM_PORT_W-1:0]  decoded_symbol,
	input wire logic [pctd_pkg::STATUS_W-1:0]    status
);

	import pctd_pkg::*;

	// one item in flight: ready is always low in the cycle after an input transfer
	`PCTD_ASSERT_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready, "ready stayed high after input transfer")

	`PCTD_ASSERT_NOW(a_found_ok, clk, arst_n, out_valid && symbol_found, status == STATUS_OK, "symbol found with error status")

	`PCTD_ASSERT_NOW(a_sym_zero, clk, arst_n, out_valid && !symbol_found, decoded_symbol == '0, "symbol nonzero without a hit")

	`PCTD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(symbol_found) && $stable(decoded_symbol) && $stable(status), "stalled result changed")

endmodule

bind prefix_code_trie_decoder_core pctd_checker u_pctd_checker (.*);

`default_nettype wire
